@@ hw/rtl/sfd_pkg.sv @@
package sfd_pkg;

  // Control characters of the link.
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_DLE = 8'h10;
  localparam logic [7:0] CH_NAK = 8'h15;

  // Commands at or above this value open a length-prefixed frame, except the one below.
  localparam logic [7:0] CMD_NEW_MIN = 8'h80;
  localparam logic [7:0] CMD_OLD_XTRA = 8'hC4;

  localparam logic [15:0] CRC_POLY = 16'h8005;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_NAK = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // Frame status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_START = 2'd1;
  localparam logic [1:0] ST_BAD_CRC = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_OLD,
    PH_NEW,
    PH_DRAIN
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] item_kind;
    logic [1:0] frame_status;
    logic       last;
  } out_t;

  // Results caused by one input item; r1 is meaningful only when two is set.
  typedef struct packed {
    logic two;
    out_t r0;
    out_t r1;
  } rec_t;

  function automatic logic [15:0] crc_feed(logic [15:0] sum, logic [7:0] b);
    logic [15:0] s;
    logic        top;
    s = sum;
    for (int k = 7; k >= 0; k--) begin
      top = s[15];
      s = {s[14:0], b[k]};
      if (top) begin
        s = s ^ CRC_POLY;
      end
    end
    return s;
  endfunction

  function automatic out_t mk_res(logic [7:0] b, logic [1:0] kind, logic [1:0] st,
                                  logic lst);
    out_t r;
    r.out_byte = b;
    r.item_kind = kind;
    r.frame_status = st;
    r.last = lst;
    return r;
  endfunction

endpackage

@@ hw/rtl/stx_etx_frame_decoder_crc16_top.sv @@
// Channel  | Handshake             | Payload                          | Direction
// ---------+-----------------------+----------------------------------+----------
// input    | push / full           | in_item_i  (rx_byte, chunk_end)  | into block
// result   | empty / pop           | out_item_o (out_byte, item_kind, | out of block
//          |                       |   frame_status, last)            |
//
// One byte is accepted per cycle while full is low; the front decodes it in that cycle,
// including the unrolled eight-step CRC update, into one record of up to two result items.
// Records wait in a Depth-entry queue and the result side delivers one item per cycle
// while pop is high, so input sustains one byte per cycle while bytes average at most one
// item each. A byte's record is registered in the queue; its items follow those queued.
// Reset is asynchronous and active low; full rises when the queue holds Depth records.
module stx_etx_frame_decoder_crc16_top #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  sfd_pkg::in_t  in_item_i,
  output logic          empty,
  input  logic          pop,
  output sfd_pkg::out_t out_item_o
);
  import sfd_pkg::*;

  logic accept;
  logic rec_push;
  rec_t rec_in;
  rec_t rec_head;
  logic q_empty;
  logic q_pop;

  // A byte is taken whenever the queue has room for its record.
  assign accept = push && !full;

  // Front: framing state machine and CRC accumulation, one byte per cycle while full is low.
  sfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .in_item_i  (in_item_i),
    .rec_push_o (rec_push),
    .rec_o      (rec_in)
  );

  // Queue of result records between the decoder and the result port.
  sfd_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_in),
    .pop_i   (q_pop),
    .rdata_o (rec_head),
    .full_o  (full),
    .empty_o (q_empty)
  );

  // Back: splits each record into its one or two result items.
  sfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (rec_head),
    .head_empty_i (q_empty),
    .head_pop_o   (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_item_o   (out_item_o)
  );

endmodule

@@ hw/rtl/sfd_front.sv @@
module sfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  sfd_pkg::in_t  in_item_i,
  output logic          rec_push_o,
  output sfd_pkg::rec_t rec_o
);
  import sfd_pkg::*;

  phase_e      ph_q, ph_d;
  logic [15:0] crc_q, crc_d;
  logic [8:0]  seen_q, seen_d;
  logic [7:0]  len_q, len_d;
  logic        esc_q, esc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;

  logic [7:0]  b;
  logic        endc;
  logic        done;
  logic        go_old;
  logic        esc_cur;
  logic        tail;
  logic [1:0]  n;
  logic [8:0]  total;
  logic [15:0] padded;
  rec_t        rec;

  assign b = in_item_i.rx_byte;
  assign endc = in_item_i.chunk_end;
  assign total = {1'b0, len_q} + 9'd2;

  // The check value is closed with zero padding once the last data byte is in.
  always_comb begin
    padded = crc_q;
    if (len_q != 8'd0) begin
      padded = crc_feed(padded, 8'h00);
      if (!len_q[0]) begin
        padded = crc_feed(padded, 8'h00);
      end
    end
  end

  // Results of the current byte.
  always_comb begin
    rec = '0;
    n = 2'd0;
    done = 1'b0;
    go_old = 1'b0;
    tail = 1'b0;
    esc_cur = esc_q;

    unique case (ph_q)
      PH_HUNT: begin
        if (b == CH_ACK || b == CH_NAK) begin
          rec.r0 = mk_res(b, (b == CH_ACK) ? KIND_ACK : KIND_NAK, ST_OK, 1'b1);
          n = 2'd1;
          done = 1'b1;
        end else if (endc) begin
          rec.r0 = mk_res(8'h00, KIND_STATUS, ST_NO_START, 1'b1);
          n = 2'd1;
        end
      end
      PH_DRAIN: begin
      end
      PH_CMD: begin
        if (b < CMD_NEW_MIN || b == CMD_OLD_XTRA) begin
          go_old = 1'b1;
          esc_cur = 1'b0;
        end else begin
          rec.r0 = mk_res(b, KIND_PAYLOAD, ST_OK, 1'b0);
          n = 2'd1;
          if (endc) begin
            rec.r1 = mk_res(8'h00, KIND_STATUS, ST_TRUNC, 1'b1);
            n = 2'd2;
          end
        end
      end
      PH_OLD: begin
        go_old = 1'b1;
      end
      PH_NEW: begin
        tail = 1'b1;
        if (seen_q < total) begin
          rec.r0 = mk_res(b, KIND_PAYLOAD, ST_OK, 1'b0);
          n = 2'd1;
        end else if (seen_q != total) begin
          rec.r0 = mk_res(8'h00, KIND_STATUS,
                          (crc_q == {crc_hi_q, b}) ? ST_OK : ST_BAD_CRC, 1'b1);
          n = 2'd1;
          done = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Old-protocol byte handling; the command byte itself may land here.
    if (go_old) begin
      tail = 1'b1;
      if (esc_cur) begin
        rec.r0 = mk_res(b, KIND_PAYLOAD, ST_OK, 1'b0);
        n = 2'd1;
      end else if (b == CH_ETX) begin
        rec.r0 = mk_res(8'h00, KIND_STATUS, ST_OK, 1'b1);
        n = 2'd1;
        done = 1'b1;
      end else if (b != CH_DLE) begin
        rec.r0 = mk_res(b, KIND_PAYLOAD, ST_OK, 1'b0);
        n = 2'd1;
      end
    end

    if (tail && !done && endc) begin
      if (n == 2'd0) begin
        rec.r0 = mk_res(8'h00, KIND_STATUS, ST_TRUNC, 1'b1);
      end else begin
        rec.r1 = mk_res(8'h00, KIND_STATUS, ST_TRUNC, 1'b1);
      end
      n = n + 2'd1;
    end

    rec.two = (n == 2'd2);
  end

  // Next phase and frame bookkeeping.
  always_comb begin
    ph_d = ph_q;
    crc_d = crc_q;
    seen_d = seen_q;
    len_d = len_q;
    esc_d = esc_q;
    crc_hi_d = crc_hi_q;

    unique case (ph_q)
      PH_HUNT: begin
        if (b == CH_STX) begin
          ph_d = PH_CMD;
        end
        if (endc) begin
          ph_d = PH_HUNT;
        end else if (done) begin
          ph_d = PH_DRAIN;
        end
      end
      PH_DRAIN: begin
        if (endc) begin
          ph_d = PH_HUNT;
        end
      end
      PH_CMD: begin
        esc_d = 1'b0;
        if (go_old) begin
          ph_d = PH_OLD;
        end else begin
          ph_d = endc ? PH_HUNT : PH_NEW;
          crc_d = crc_feed(16'h0000, b);
          seen_d = 9'd1;
          len_d = 8'h00;
          crc_hi_d = 8'h00;
        end
      end
      PH_OLD: begin
      end
      PH_NEW: begin
        if (seen_q == 9'd1) begin
          len_d = b;
          crc_d = crc_feed(crc_q, b);
          seen_d = 9'd2;
        end else if (seen_q < total) begin
          crc_d = crc_feed(crc_q, b);
          seen_d = seen_q + 9'd1;
        end else if (seen_q == total) begin
          crc_hi_d = b;
          crc_d = padded;
          seen_d = seen_q + 9'd1;
        end
      end
      default: begin
        ph_d = PH_HUNT;
      end
    endcase

    if (go_old) begin
      if (esc_cur) begin
        esc_d = 1'b0;
      end else if (b == CH_DLE) begin
        esc_d = 1'b1;
      end
    end

    if (tail) begin
      if (done) begin
        esc_d = 1'b0;
        ph_d = endc ? PH_HUNT : PH_DRAIN;
      end else if (endc) begin
        esc_d = 1'b0;
        ph_d = PH_HUNT;
      end
    end
  end

  assign rec_push_o = in_valid_i && (n != 2'd0);
  assign rec_o = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_HUNT;
      crc_q <= '0;
      seen_q <= '0;
      len_q <= '0;
      esc_q <= 1'b0;
      crc_hi_q <= '0;
    end else if (in_valid_i) begin
      ph_q <= ph_d;
      crc_q <= crc_d;
      seen_q <= seen_d;
      len_q <= len_d;
      esc_q <= esc_d;
      crc_hi_q <= crc_hi_d;
    end
  end

  a_push_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push_o |-> in_valid_i)
    else $error("record pushed without an accepted item");

  a_new_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_NEW) |-> (seen_q != 9'd0 && seen_q <= total + 9'd1))
    else $error("byte count out of frame bounds");

  a_escape_only_old: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (ph_q == PH_OLD))
    else $error("escape pending outside an old-protocol frame");

  a_chunk_end_rehunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && endc) |=> (ph_q == PH_HUNT))
    else $error("chunk end did not return to hunting");

endmodule

@@ hw/rtl/sfd_fifo.sv @@
module sfd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfd_pkg::rec_t wdata_i,
  input  logic          pop_i,
  output sfd_pkg::rec_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import sfd_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [AW:0] DepthCnt = (AW + 1)'(Depth);

  rec_t          mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign full_o = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == DepthCnt) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with count");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a write");

endmodule

@@ hw/rtl/sfd_back.sv @@
module sfd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfd_pkg::rec_t head_i,
  input  logic          head_empty_i,
  output logic          head_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output sfd_pkg::out_t out_item_o
);
  import sfd_pkg::*;

  // Set while the second result of the head record is on the ports.
  logic sel_q, sel_d;
  logic take;

  assign empty_o = head_empty_i;
  assign take = pop_i && !head_empty_i;
  assign out_item_o = sel_q ? head_i.r1 : head_i.r0;
  assign head_pop_o = take && (sel_q || !head_i.two);

  always_comb begin
    sel_d = sel_q;
    if (take) begin
      sel_d = !sel_q && head_i.two;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

  a_sel_has_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (!head_empty_i && head_i.two))
    else $error("second result selected without a two-result record");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !sel_q && head_i.two) |=> sel_q)
    else $error("second result skipped");

  a_first_is_frame_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!head_empty_i && head_i.two) |-> (head_i.r0.last == 1'b0 && head_i.r1.last == 1'b1))
    else $error("two-result record not payload then frame end");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import sfd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // The run stops when no item has moved on either side for this many cycles.
  localparam int unsigned StallLimit = 2000;
  // Cycles to wait after the last expected item, so that stray items show up.
  localparam int unsigned TailCycles = 20;
  // Frame bytes to send in the random phase.
  localparam int unsigned RandomBytes = 1650;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic push;
  logic full;
  in_t  in_item;
  logic empty;
  logic pop;
  out_t out_item;

  // When clear, neither side inserts idle cycles.
  bit idle_en = 1'b1;
  int unsigned fail_count = 0;
  int unsigned frame_bytes = 0;

  // Expected decoder output items, oldest first.
  out_t decoded_q[$];

  // Shadow copy of the decoder state.
  phase_e      dec_phase = PH_HUNT;
  logic [15:0] dec_crc = '0;
  logic [8:0]  dec_count = '0;
  logic [7:0]  dec_len = '0;
  logic        dec_esc = 1'b0;
  logic [7:0]  dec_crc_hi = '0;

  stx_etx_frame_decoder_crc16_top uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // CRC-16 with polynomial 0x8005, data shifted in MSB first behind the register.
  function automatic logic [15:0] crc16_shift(logic [15:0] acc, logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = acc[15];
      acc = {acc[14:0], d[i]};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  // The check word that a length-prefixed frame must carry to be accepted.
  function automatic logic [15:0] frame_check_word(logic [7:0] cmd, byte_q_t data);
    logic [15:0] acc;
    acc = crc16_shift(crc16_shift(16'h0000, cmd), 8'(data.size()));
    foreach (data[i]) acc = crc16_shift(acc, data[i]);
    if (data.size() != 0) begin
      acc = crc16_shift(acc, 8'h00);
      if (data.size() % 2 == 0) begin
        acc = crc16_shift(acc, 8'h00);
      end
    end
    return acc;
  endfunction

  // A byte that the decoder skips while it hunts for the start of a frame.
  function automatic logic [7:0] hunt_noise();
    logic [7:0] nb;
    do nb = 8'($urandom_range(0, 255));
    while (nb == CH_STX || nb == CH_ACK || nb == CH_NAK);
    return nb;
  endfunction

  task automatic expect_item(input logic [7:0] b, input logic [1:0] kind,
                             input logic [1:0] st, input logic lst);
    out_t r;
    r.out_byte = b;
    r.item_kind = kind;
    r.frame_status = st;
    r.last = lst;
    decoded_q.push_back(r);
  endtask

  // Advances the shadow decoder by one received byte and queues what it emits.
  task automatic decode_rx_byte(input logic [7:0] b, input logic ce);
    logic        done;
    logic [15:0] calc;
    logic [8:0]  total;
    done = 1'b0;
    if (dec_phase == PH_HUNT) begin
      if (b == CH_STX) begin
        dec_phase = PH_CMD;
      end else if (b == CH_ACK || b == CH_NAK) begin
        expect_item(b, (b == CH_ACK) ? KIND_ACK : KIND_NAK, ST_OK, 1'b1);
        done = 1'b1;
      end
      if (done) begin
        dec_phase = ce ? PH_HUNT : PH_DRAIN;
      end else if (ce) begin
        // The chunk ran out before a frame began, even if STX was its last byte.
        expect_item(8'h00, KIND_STATUS, ST_NO_START, 1'b1);
        dec_phase = PH_HUNT;
      end
    end else if (dec_phase == PH_DRAIN) begin
      if (ce) begin
        dec_phase = PH_HUNT;
      end
    end else if (dec_phase == PH_CMD && b >= CMD_NEW_MIN && b != CMD_OLD_XTRA) begin
      // Length-prefixed frame: the command byte is payload and starts the CRC.
      dec_phase = PH_NEW;
      dec_esc = 1'b0;
      dec_crc = crc16_shift(16'h0000, b);
      dec_count = 9'd1;
      dec_len = 8'h00;
      dec_crc_hi = 8'h00;
      expect_item(b, KIND_PAYLOAD, ST_OK, 1'b0);
      if (ce) begin
        expect_item(8'h00, KIND_STATUS, ST_TRUNC, 1'b1);
        dec_phase = PH_HUNT;
      end
    end else begin
      // An old-protocol command is handled as the first byte of its body.
      if (dec_phase == PH_CMD) begin
        dec_esc = 1'b0;
        dec_phase = PH_OLD;
      end
      if (dec_phase == PH_OLD) begin
        if (dec_esc) begin
          dec_esc = 1'b0;
          expect_item(b, KIND_PAYLOAD, ST_OK, 1'b0);
        end else if (b == CH_ETX) begin
          expect_item(8'h00, KIND_STATUS, ST_OK, 1'b1);
          done = 1'b1;
        end else if (b == CH_DLE) begin
          dec_esc = 1'b1;
        end else begin
          expect_item(b, KIND_PAYLOAD, ST_OK, 1'b0);
        end
      end else begin
        total = {1'b0, dec_len} + 9'd2;
        if (dec_count == 9'd1) begin
          dec_len = b;
          dec_crc = crc16_shift(dec_crc, b);
          dec_count = 9'd2;
          expect_item(b, KIND_PAYLOAD, ST_OK, 1'b0);
        end else if (dec_count < total) begin
          dec_crc = crc16_shift(dec_crc, b);
          dec_count = dec_count + 9'd1;
          expect_item(b, KIND_PAYLOAD, ST_OK, 1'b0);
        end else if (dec_count == total) begin
          dec_crc_hi = b;
          dec_count = dec_count + 9'd1;
        end else begin
          // Zero padding: none for an empty body, one byte when command, length
          // and body add up to an odd count, two bytes otherwise.
          calc = dec_crc;
          if (dec_len != 8'h00) begin
            calc = crc16_shift(calc, 8'h00);
            if (!dec_len[0]) begin
              calc = crc16_shift(calc, 8'h00);
            end
          end
          expect_item(8'h00, KIND_STATUS, ({dec_crc_hi, b} == calc) ? ST_OK : ST_BAD_CRC,
                      1'b1);
          done = 1'b1;
        end
      end
      if (done) begin
        dec_esc = 1'b0;
        dec_phase = ce ? PH_HUNT : PH_DRAIN;
      end else if (ce) begin
        expect_item(8'h00, KIND_STATUS, ST_TRUNC, 1'b1);
        dec_esc = 1'b0;
        dec_phase = PH_HUNT;
      end
    end
  endtask

  // Offers one byte, holds it until the block takes it, then predicts its output.
  // Push stays high into the next call, so back-to-back bytes go one per cycle while full is low.
  task automatic send_byte(input logic [7:0] b, input logic ce);
    while (idle_en && $urandom_range(0, 99) < 11) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item.rx_byte <= b;
    in_item.chunk_end <= ce;
    do @(posedge clk_i); while (full);
    decode_rx_byte(b, ce);
  endtask

  // Sends a frame as one chunk. Sometimes hunting noise goes first, sometimes the
  // chunk ends early inside the frame, and sometimes trailing bytes follow it.
  task automatic ship_frame(input byte_q_t fr);
    int cut;
    int trail;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3)) fr.push_front(hunt_noise());
    end
    cut = fr.size() - 1;
    if ($urandom_range(0, 99) < 12) begin
      cut = $urandom_range(0, fr.size() - 1);
    end
    trail = 0;
    if (cut == fr.size() - 1 && $urandom_range(0, 99) < 25) begin
      trail = $urandom_range(1, 3);
    end
    for (int i = 0; i <= cut; i++) begin
      send_byte(fr[i], i == cut && trail == 0);
      frame_bytes++;
    end
    for (int i = 1; i <= trail; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == trail);
    end
  endtask

  task automatic test_ack_nak();
    send_byte(CH_ACK, 1'b1);
    // The bytes after NAK are dropped, including an STX.
    send_byte(CH_NAK, 1'b0);
    send_byte(CH_STX, 1'b1);
  endtask

  task automatic test_no_start();
    send_byte(8'h55, 1'b1);
    send_byte(CH_STX, 1'b1);
  endtask

  task automatic test_old_protocol();
    // A command of ETX closes the frame at once.
    send_byte(CH_STX, 1'b0);
    send_byte(CH_ETX, 1'b1);
    // DLE as command escapes ETX; a doubled DLE gives one DLE of payload.
    send_byte(CH_STX, 1'b0);
    send_byte(CH_DLE, 1'b0);
    send_byte(CH_ETX, 1'b0);
    send_byte(CH_DLE, 1'b0);
    send_byte(CH_DLE, 1'b0);
    send_byte(CH_ETX, 1'b1);
    // The one high command that still opens an old frame, cut off at once.
    send_byte(CH_STX, 1'b0);
    send_byte(CMD_OLD_XTRA, 1'b1);
  endtask

  task automatic test_new_protocol();
    byte_q_t     body;
    logic [15:0] cw;
    // Empty body: the check word is the command and length themselves.
    send_byte(CH_STX, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);
    // A one-byte body with a damaged check word.
    body = '{8'hA5};
    cw = frame_check_word(8'hFF, body) ^ 16'h0001;
    send_byte(CH_STX, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(cw[15:8], 1'b0);
    send_byte(cw[7:0], 1'b1);
  endtask

  // Mostly well-formed frames of both kinds with random content, plus ACK/NAK,
  // bad check words, early chunk ends and plain noise.
  task automatic test_random_traffic();
    byte_q_t     fr;
    byte_q_t     body;
    logic [7:0]  cmd;
    logic [7:0]  d;
    logic [15:0] cw;
    int          pick;
    while (frame_bytes < RandomBytes) begin
      // A long stretch in the middle runs with both sides at full rate.
      idle_en = !(frame_bytes >= 600 && frame_bytes < 900);
      fr = {};
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cmd = 8'($urandom_range(8'h80, 8'hFF));
        if (cmd == CMD_OLD_XTRA) begin
          cmd = 8'hC5;
        end
        body = {};
        // Most bodies are short; a few are long, up to the full length range.
        repeat (($urandom_range(0, 99) < 3) ? $urandom_range(128, 255) :
                $urandom_range(0, 12)) body.push_back(8'($urandom_range(0, 255)));
        cw = frame_check_word(cmd, body);
        if ($urandom_range(0, 99) < 15) begin
          cw = cw ^ (16'h0001 << $urandom_range(0, 15));
        end
        fr = {CH_STX, cmd, 8'(body.size())};
        foreach (body[i]) fr.push_back(body[i]);
        fr.push_back(cw[15:8]);
        fr.push_back(cw[7:0]);
      end else if (pick < 75) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          cmd = CH_ETX;
        end else if (pick < 20) begin
          cmd = CH_DLE;
        end else if (pick < 30) begin
          cmd = CMD_OLD_XTRA;
        end else begin
          cmd = 8'($urandom_range(0, 8'h7F));
        end
        fr = {CH_STX, cmd};
        if (cmd != CH_ETX) begin
          if (cmd == CH_DLE) begin
            fr.push_back(8'($urandom_range(0, 255)));
          end
          repeat ($urandom_range(0, 10)) begin
            d = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 25) begin
              case ($urandom_range(0, 3))
                0: d = CH_ETX;
                1: d = CH_DLE;
                2: d = CH_STX;
                default: d = CH_ACK;
              endcase
            end
            // ETX and DLE inside the body are always escaped, other bytes now and then.
            if (d == CH_ETX || d == CH_DLE || $urandom_range(0, 9) == 0) begin
              fr.push_back(CH_DLE);
            end
            fr.push_back(d);
          end
          fr.push_back(CH_ETX);
        end
      end else if (pick < 87) begin
        fr = {($urandom_range(0, 1) != 0) ? CH_ACK : CH_NAK};
      end else begin
        repeat ($urandom_range(1, 4)) fr.push_back(hunt_noise());
      end
      ship_frame(fr);
    end
    idle_en = 1'b1;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: pops at random and checks every item taken against the oldest
  // expectation. Values are read right after the edge, so they are the ones
  // the block presented when the item was taken.
  initial begin : result_side
    out_t want;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected item: out_byte %0h, item_kind %0d, frame_status %0d, last %0d",
                 out_item.out_byte, out_item.item_kind, out_item.frame_status,
                 out_item.last);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", want.out_byte, out_item.out_byte);
          check_field("item_kind", want.item_kind, out_item.item_kind);
          check_field("frame_status", want.frame_status, out_item.frame_status);
          check_field("last", want.last, out_item.last);
        end
      end
      pop <= rst_ni && (!idle_en || $urandom_range(0, 99) >= 11);
    end
  end

  // Watchdog: counts cycles in which neither side moves an item.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("stx_etx_frame_decoder_crc16_top regression: fail");
    $finish;
  end

  initial begin
    push <= 1'b0;
    in_item <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ack_nak();
    test_no_start();
    test_old_protocol();
    test_new_protocol();
    test_random_traffic();
    push <= 1'b0;

    // Let the queue drain, then give late or extra items a chance to appear.
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("stx_etx_frame_decoder_crc16_top regression: pass");
    end else begin
      $display("stx_etx_frame_decoder_crc16_top regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_front.sv
hw/rtl/sfd_fifo.sv
hw/rtl/sfd_back.sv
hw/rtl/stx_etx_frame_decoder_crc16_top.sv
tb/tb_top.sv
